>>> sv/periodic_event_scheduler_defines.svh
// Assertion helpers shared by the checker.
`ifndef PERIODIC_EVENT_SCHEDULER_DEFINES_SVH
`define PERIODIC_EVENT_SCHEDULER_DEFINES_SVH

// Checked only outside reset.
`define PES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pes_pkg.sv
`timescale 1ns / 1ps
package pes_pkg;

  localparam int CAPACITY = 16;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CFG_AW   = 3;

  // input func codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FIRED   = 3'd1;
  localparam logic [2:0] ST_ADVANCE = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_FIRE = 2'd2;

  // register index
  localparam logic REG_START_TIME = 1'b0;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] due;
    logic [15:0] per;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     item;
  } cell_ctl_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  event_id;
    logic [31:0] due_time;
    logic [15:0] period;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  fired_id;
    logic [31:0] current_time;
    logic [4:0]  pending_count;
  } out_item_t;

endpackage

>>> sv/pes_cell.sv
`timescale 1ns / 1ps
module pes_cell import pes_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  logic      le_prev,
  input  logic      le_next,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      le
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Entry sits at or before the incoming item in sort order.
  assign le  = valid && (ent_r.due <= ctl.item.due);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      CELL_INS: begin
        // keep if due at or before the item, take the item at the boundary, else shift right
        if (!le) begin
          ent_nxt = le_prev ? ctl.item : prev_ent;
        end
      end
      CELL_FIRE: begin
        // head leaves: shift left up to the slot where the item lands
        if (le_next) begin
          ent_nxt = next_ent;
        end else if (le) begin
          ent_nxt = ctl.item;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> sv/periodic_event_scheduler.sv
`timescale 1ns / 1ps
// Periodic event scheduler: a row of CAPACITY cells holds pending events sorted
// by due time, earliest in cell 0, ties kept in arrival order. An add item
// inserts an event (status full-dropped when the row is full); a step item
// fires the head when it is due at or before the current time, reporting its id
// and re-inserting it at current time plus its period (saturating), otherwise
// moves the current time to the head's due time, or reports empty. Each item
// is first decoded against cell 0 with the reschedule time formed, and is then
// shifted and inserted across all cells at once while the result register is
// loaded. A new item is not taken while one is in flight; it is taken once that
// result register is free or being drained.
// Writing start_time also loads the current time.
module periodic_event_scheduler import pes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic             busy_r;
  logic [1:0]       op_r, op_nxt;
  logic [2:0]       st_r, st_nxt;
  entry_t           item_r, item_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [31:0]      gt_r;
  logic [31:0]      start_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic      accept;
  logic      cfg_wr;
  logic      cfg_idx;
  entry_t    head;
  logic [32:0] sum;
  logic [31:0] ndue;
  cell_ctl_t ctl;

  entry_t ent     [CAPACITY];
  logic   le      [CAPACITY];
  entry_t ent_ext [CAPACITY+2];
  logic   le_ext  [CAPACITY+2];

  assign in_stall  = busy_r | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_AW-1];
  assign cfg_prdata = (cfg_idx == REG_START_TIME) ? start_r : 32'd0;

  // Cell row
  assign ctl.op   = busy_r ? op_r : CELL_HOLD;
  assign ctl.item = item_r;

  assign ent_ext[0]          = '0;
  assign le_ext[0]           = 1'b1;
  assign ent_ext[CAPACITY+1] = '0;
  assign le_ext[CAPACITY+1]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ent_ext[i+1] = ent[i];
    assign le_ext[i+1]  = le[i];

    pes_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (OCC_W'(i) < occ_r),
      .le_prev  (le_ext[i]),
      .le_next  (le_ext[i+2]),
      .prev_ent (ent_ext[i]),
      .next_ent (ent_ext[i+2]),
      .ent      (ent[i]),
      .le       (le[i])
    );
  end

  // Decode against the head
  assign head = ent[0];
  assign sum  = {1'b0, gt_r} + 33'(head.per);
  assign ndue = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    op_nxt   = CELL_HOLD;
    st_nxt   = ST_ADDED;
    item_nxt = '{id: in_data.event_id, due: in_data.due_time, per: in_data.period};
    if (in_data.func == FUNC_ADD) begin
      if (occ_r == OCC_W'(CAPACITY)) begin
        st_nxt = ST_FULL;
      end else begin
        op_nxt = CELL_INS;
      end
    end else if (occ_r == '0) begin
      st_nxt = ST_EMPTY;
    end else if (head.due <= gt_r) begin
      st_nxt   = ST_FIRED;
      op_nxt   = CELL_FIRE;
      item_nxt = '{id: head.id, due: ndue, per: head.per};
    end else begin
      st_nxt   = ST_ADVANCE;
      item_nxt = head;
    end
  end

  assign occ_nxt = (op_r == CELL_INS) ? occ_r + OCC_W'(1) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      occ_r       <= '0;
      gt_r        <= 32'd0;
      start_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        busy_r <= 1'b1;
        op_r   <= op_nxt;
        st_r   <= st_nxt;
        item_r <= item_nxt;
      end
      if (busy_r) begin
        busy_r                  <= 1'b0;
        occ_r                   <= occ_nxt;
        out_valid_r             <= 1'b1;
        out_r.status            <= st_r;
        out_r.fired_id          <= (st_r == ST_FIRED) ? item_r.id : 8'd0;
        out_r.current_time      <= (st_r == ST_ADVANCE) ? item_r.due : gt_r;
        out_r.pending_count     <= 5'(occ_nxt);
        if (st_r == ST_ADVANCE) begin
          gt_r <= item_r.due;
        end
      end
      if (cfg_wr && cfg_idx == REG_START_TIME) begin
        start_r <= cfg_pwdata;
        gt_r    <= cfg_pwdata;
      end
    end
  end

endmodule

>>> sv/pes_checker.sv
`timescale 1ns / 1ps
`include "periodic_event_scheduler_defines.svh"
module pes_checker import pes_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `PES_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `PES_ASSERT(a_busy_after_transfer, in_valid && !in_stall |=> in_stall, "input taken while busy")
  `PES_ASSERT(a_empty_count, out_valid && out_data.status == ST_EMPTY |-> out_data.pending_count == 5'd0, "empty status with pending events")
  `PES_ASSERT(a_fire_count, out_valid && out_data.status == ST_FIRED |-> out_data.pending_count != 5'd0, "fired event missing from table")
  `PES_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (.*);

>>> dv/tb_periodic_event_scheduler.sv
`timescale 1ns / 1ps
module tb_periodic_event_scheduler;
  import pes_pkg::*;

  localparam int NUM_REGS   = 1;
  localparam int MAX_GAP    = 19;
  localparam int SETTLE_CYC = 20;
  localparam int HOLD_CYC   = 150;
  localparam int MAX_PRINTS = 50;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  periodic_event_scheduler dut (.*);

  // Scheduler state as the testbench sees it.
  entry_t      sched_tab [CAPACITY];
  int unsigned sched_occ   = 0;
  logic [31:0] sched_now   = '0;
  logic [31:0] sched_start = '0;

  out_item_t   expected_q [$];
  int          errors    = 0;
  bit          tx_gaps   = 1'b0;
  bit          rx_gaps   = 1'b0;
  int          hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** periodic_event_scheduler: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Insert after every entry due at or before the new one.
  function automatic void tab_insert(input entry_t e);
    int unsigned pos;
    pos = 0;
    if (sched_occ >= CAPACITY) return;
    while (pos < sched_occ && sched_tab[pos].due <= e.due) pos++;
    for (int unsigned k = sched_occ; k > pos; k--) sched_tab[k] = sched_tab[k - 1];
    sched_tab[pos] = e;
    sched_occ++;
  endfunction

  function automatic out_item_t sched_predict(input in_item_t item);
    out_item_t   r;
    entry_t      e;
    logic [32:0] sum;
    r = '0;
    if (item.func == FUNC_ADD) begin
      if (sched_occ >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        e.id  = item.event_id;
        e.due = item.due_time;
        e.per = item.period;
        tab_insert(e);
        r.status = ST_ADDED;
      end
    end else if (sched_occ == 0) begin
      r.status = ST_EMPTY;
    end else if (sched_tab[0].due <= sched_now) begin
      e = sched_tab[0];
      for (int unsigned k = 1; k < sched_occ; k++) sched_tab[k - 1] = sched_tab[k];
      sched_occ--;
      sum   = {1'b0, sched_now} + 33'(e.per);
      e.due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      tab_insert(e);
      r.status   = ST_FIRED;
      r.fired_id = e.id;
    end else begin
      sched_now = sched_tab[0].due;
      r.status  = ST_ADVANCE;
    end
    r.current_time  = sched_now;
    r.pending_count = 5'(sched_occ);
    return r;
  endfunction

  function automatic in_item_t make_item(input logic func, input logic [7:0] id,
                                         input logic [31:0] due, input logic [15:0] per);
    in_item_t it;
    it.func     = func;
    it.event_id = id;
    it.due_time = due;
    it.period   = per;
    return it;
  endfunction

  function automatic in_item_t random_item(input int step_pct);
    return make_item(($urandom_range(0, 99) < step_pct) ? FUNC_STEP : FUNC_ADD,
                     8'($urandom), $urandom, 16'($urandom));
  endfunction

  // Keep valid high across back-to-back transfers; drop it only for a gap or a drain.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(sched_predict(item));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_START_TIME) begin
      sched_start = value;
      sched_now   = value;
    end
  endtask

  task automatic check_start_time();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'(REG_START_TIME * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== sched_start)
      report_mismatch($sformatf("start_time read %h want %h", cfg_prdata, sched_start));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        stall_left = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no pending item", out_data));
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", out_data.status, want.status));
        if (out_data.fired_id !== want.fired_id)
          report_mismatch($sformatf("fired_id %h want %h", out_data.fired_id, want.fired_id));
        if (out_data.current_time !== want.current_time)
          report_mismatch($sformatf("current_time %h want %h",
                                    out_data.current_time, want.current_time));
        if (out_data.pending_count !== want.pending_count)
          report_mismatch($sformatf("pending_count %0d want %0d",
                                    out_data.pending_count, want.pending_count));
      end
    end
  end

  task automatic test_registers();
    check_start_time();
    write_reg(REG_START_TIME, 32'hFFFF_FFFF);
    check_start_time();
    // unmapped index: must be dropped
    write_reg(NUM_REGS, 32'h1234_5678);
    check_start_time();
    write_reg(REG_START_TIME, 32'h0000_0000);
    check_start_time();
  endtask

  task automatic test_directed();
    send_item(make_item(FUNC_STEP, 8'h00, 32'h0, 16'h0));
    wait_drain();
    // near the top of the time range so the reschedule saturates
    write_reg(REG_START_TIME, 32'hFFFF_FF00);
    send_item(make_item(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 16'h0000));
    send_item(make_item(FUNC_ADD, 8'h00, 32'h0000_0000, 16'hFFFF));
    repeat (4) send_item(make_item(FUNC_STEP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    wait_drain();
    // equal due times: first added fires first
    write_reg(REG_START_TIME, 32'h0000_0000);
    send_item(make_item(FUNC_ADD, 8'h5A, 32'd5, 16'd3));
    send_item(make_item(FUNC_ADD, 8'hA5, 32'd5, 16'd1));
    repeat (4) send_item(make_item(FUNC_STEP, 8'h00, 32'h0, 16'h0));
    wait_drain();
  endtask

  task automatic test_table_fill();
    logic [31:0] due;
    logic [15:0] per;
    while (sched_occ < CAPACITY) begin
      case ($urandom_range(0, 3))
        0:       due = sched_now;
        1:       due = sched_tab[$urandom_range(0, sched_occ - 1)].due;
        2:       due = sched_now + $urandom_range(1, 40);
        default: due = $urandom;
      endcase
      per = $urandom_range(0, 1) ? 16'($urandom_range(1, 12)) : 16'($urandom_range(1, 65535));
      send_item(make_item(FUNC_ADD, 8'($urandom), due, per));
    end
    send_item(make_item(FUNC_ADD, 8'h3C, sched_now, 16'd1));
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_gaps   = 1'b0;
    hold_left = HOLD_CYC;
    repeat (30) send_item(random_item(90));
    wait_drain();
    repeat (10) send_item(random_item(90));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int chunks, input int per_chunk);
    logic [31:0] new_start;
    for (int c = 0; c < chunks; c++) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_chunk; n++) send_item(random_item(85));
      wait_drain();
      case ($urandom_range(0, 3))
        0:       new_start = '0;
        1:       new_start = $urandom_range(0, 2000);
        2:       new_start = $urandom;
        default: new_start = sched_now;
      endcase
      write_reg(REG_START_TIME, new_start);
    end
  endtask

  task automatic test_time_saturation();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    write_reg(REG_START_TIME, 32'hFFFF_FFFF);
    repeat (40) send_item(random_item(80));
    wait_drain();
    write_reg(REG_START_TIME, 32'h0000_0000);
    repeat (20) send_item(random_item(80));
    wait_drain();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_registers();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_directed();
    test_table_fill();
    test_backpressure();
    test_random_traffic(12, 100);
    test_time_saturation();

    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0)
      $display("** periodic_event_scheduler: PASSED **");
    else
      $display("** periodic_event_scheduler: FAILED **");
    $finish;
  end

endmodule
